### sv/hpf_pkg.sv
// Shared constants and control types for the hysteresis peak finder.
package hpf_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int TIME_BITS_DEF   = 16;

    // Output queue geometry.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Result pushes from the segment logic for one item; push1 implies push0.
    typedef struct packed {
        logic push0;
        logic push1;
    } t_push;

    // Queue status seen by the top level.
    typedef struct packed {
        logic [Q_CNT_W-1:0] level;
        logic               room2;
    } t_q_stat;

endpackage

### sv/hysteresis_peak_finder.sv
// Top level of the hysteresis peak finder: input register, segment logic, result queue.
//
// Usage:
//   Input stream (i_s_axis_*): one ADC sample per item, with its time stamp in
//   tdata and tlast marking the final sample of a waveform.
//   Output stream (o_m_axis_*): one peak per item (time, value), tlast set on
//   the last peak produced by a given input sample.
//   i_cfg_we / i_cfg_wdata write the hysteresis threshold (ADC counts); write
//   it only while the block is idle.
// Timing:
//   An accepted sample lands in the input register. It advances only when the
//   queue has room for two peaks; the segment logic then updates its state and
//   pushes 0, 1 or 2 peaks into a four-entry result queue. Throughput is one
//   sample per cycle while the queue has that room; a sample that closes a
//   segment and is also marked last yields two peaks, which leave one per cycle
//   while the receiver is ready. A stalled receiver thus backs up into
//   o_s_axis_tready once the queue holds more than two peaks.
// Reset:
//   Synchronous, active low. Clears the threshold, the segment state, the input
//   valid flag and the queue pointers and count; no segment is open after reset.
module hysteresis_peak_finder #(
    parameter int SAMPLE_BITS = hpf_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = hpf_pkg::TIME_BITS_DEF,
    localparam int DW         = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [SAMPLE_BITS-1:0] i_cfg_wdata,   // threshold
    // sample stream in
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [DW-1:0]          i_s_axis_tdata,  // adc_sample, sample_time, zero pad
    input  logic                   i_s_axis_tlast,  // last_sample
    // peak stream out
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [DW-1:0]          o_m_axis_tdata,  // peak_time, peak_value, zero pad
    output logic                   o_m_axis_tlast   // last_of_run
);

    localparam int RES_W = TIME_BITS + SAMPLE_BITS + 1;

    // Input register
    logic                   r_in_vld;
    logic [SAMPLE_BITS-1:0] r_in_sample;
    logic [TIME_BITS-1:0]   r_in_time;
    logic                   r_in_last;

    logic                   w_accept;
    logic                   w_adv;
    logic                   w_pop;

    hpf_pkg::t_push         w_push;
    hpf_pkg::t_push         w_push_q;
    hpf_pkg::t_q_stat       w_stat;
    logic [RES_W-1:0]       w_res0;
    logic [RES_W-1:0]       w_res1;
    logic [RES_W-1:0]       w_head;

    // Advance the held sample only when the queue can absorb two peaks.
    assign w_adv           = r_in_vld && w_stat.room2;
    assign o_s_axis_tready = !r_in_vld || w_adv;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_sample <= i_s_axis_tdata[SAMPLE_BITS-1:0];
            r_in_time   <= i_s_axis_tdata[SAMPLE_BITS +: TIME_BITS];
            r_in_last   <= i_s_axis_tlast;
        end
    end

    hpf_seg #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_seg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_adv),
        .i_sample    (r_in_sample),
        .i_time      (r_in_time),
        .i_last      (r_in_last),
        .o_push      (w_push),
        .o_res0      (w_res0),
        .o_res1      (w_res1)
    );

    // Pushes count only on a real step.
    assign w_push_q.push0 = w_adv && w_push.push0;
    assign w_push_q.push1 = w_adv && w_push.push1;

    assign w_pop = o_m_axis_tvalid && i_m_axis_tready;

    hpf_outq #(
        .W (RES_W)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push_q),
        .i_d0    (w_res0),
        .i_d1    (w_res1),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    assign o_m_axis_tvalid = (w_stat.level != '0);
    assign o_m_axis_tdata  = DW'(w_head[RES_W-2:0]);
    assign o_m_axis_tlast  = w_head[RES_W-1];

`ifndef SYNTH
    // Queue never holds more than its depth.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.level <= hpf_pkg::Q_CNT_W'(hpf_pkg::Q_DEPTH))
        else $error("result queue overflow");

    // A sample marked last always produces a peak on the next cycle.
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> o_m_axis_tvalid)
        else $error("last sample produced no peak");

    // Second push only alongside the first.
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_q.push1 |-> w_push_q.push0)
        else $error("second result pushed without first");

    // A held sample with a full-enough queue keeps the input stalled.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_stat.room2) |-> !o_s_axis_tready)
        else $error("input accepted while queue lacks room");
`endif

endmodule

### sv/hpf_seg.sv
// Segment tracker: threshold register, segment state and result selection.
module hpf_seg #(
    parameter int SAMPLE_BITS = hpf_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = hpf_pkg::TIME_BITS_DEF,
    localparam int RES_W      = TIME_BITS + SAMPLE_BITS + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [SAMPLE_BITS-1:0] i_cfg_wdata,
    input  logic                   i_step,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [TIME_BITS-1:0]   i_time,
    input  logic                   i_last,
    output hpf_pkg::t_push         o_push,
    output logic [RES_W-1:0]       o_res0,   // {last_of_run, peak_value, peak_time}
    output logic [RES_W-1:0]       o_res1    // {last_of_run, peak_value, peak_time}
);

    logic [SAMPLE_BITS-1:0] r_thr;
    logic                   r_open;
    logic [SAMPLE_BITS-1:0] r_max;
    logic [TIME_BITS-1:0]   r_mtime;
    logic [SAMPLE_BITS-1:0] r_prev;
    logic                   r_fall;

    logic                   n_open;
    logic [SAMPLE_BITS-1:0] n_max;
    logic [TIME_BITS-1:0]   n_mtime;
    logic [SAMPLE_BITS-1:0] n_prev;
    logic                   n_fall;

    logic [SAMPLE_BITS-1:0] w_down;
    logic [SAMPLE_BITS-1:0] w_up;
    logic                   w_drop;
    logic                   w_armed;
    logic                   w_close;

    // Differences only matter when positive; each is gated by a compare, so a wrapped value is never used.
    assign w_down  = r_prev - i_sample;
    assign w_up    = i_sample - r_prev;
    assign w_drop  = (r_prev > i_sample) && (w_down > r_thr);
    assign w_armed = r_fall || w_drop;
    assign w_close = r_open && w_armed && (i_sample > r_prev) && (w_up > r_thr);

    always_comb begin
        n_max   = r_max;
        n_mtime = r_mtime;
        n_prev  = i_sample;
        n_fall  = w_armed;
        if (!r_open || w_close) begin
            n_max   = i_sample;
            n_mtime = i_time;
            n_fall  = 1'b0;
        end else if (i_sample > r_max) begin
            n_max   = i_sample;
            n_mtime = i_time;
        end
        n_open = !i_last;
    end

    always_comb begin
        o_push.push0 = w_close || i_last;
        o_push.push1 = w_close && i_last;
        if (w_close) begin
            o_res0 = {!i_last, r_max, r_mtime};
        end else begin
            o_res0 = {1'b1, n_max, n_mtime};
        end
        o_res1 = {1'b1, n_max, n_mtime};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= '0;
            r_open  <= 1'b0;
            r_max   <= '0;
            r_mtime <= '0;
            r_prev  <= '0;
            r_fall  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (i_step) begin
                r_open  <= n_open;
                r_max   <= n_max;
                r_mtime <= n_mtime;
                r_prev  <= n_prev;
                r_fall  <= n_fall;
            end
        end
    end

endmodule

### sv/hpf_outq.sv
// Small result queue: up to two writes and one read per cycle.
module hpf_outq #(
    parameter int W = 27
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hpf_pkg::t_push   i_push,
    input  logic [W-1:0]     i_d0,
    input  logic [W-1:0]     i_d1,
    input  logic             i_pop,
    output logic [W-1:0]     o_head,
    output hpf_pkg::t_q_stat o_stat
);

    logic [W-1:0]                   r_mem [hpf_pkg::Q_DEPTH];
    logic [hpf_pkg::Q_PTR_W-1:0]    r_wp;
    logic [hpf_pkg::Q_PTR_W-1:0]    r_rp;
    logic [hpf_pkg::Q_CNT_W-1:0]    r_cnt;

    logic [hpf_pkg::Q_PTR_W-1:0]    w_wp1;
    logic [hpf_pkg::Q_CNT_W-1:0]    w_npush;
    logic [hpf_pkg::Q_CNT_W-1:0]    n_cnt;

    assign w_wp1   = r_wp + hpf_pkg::Q_PTR_W'(1);
    assign w_npush = hpf_pkg::Q_CNT_W'(i_push.push0) + hpf_pkg::Q_CNT_W'(i_push.push1);
    assign n_cnt   = r_cnt + w_npush - hpf_pkg::Q_CNT_W'(i_pop);

    assign o_head       = r_mem[r_rp];
    assign o_stat.level = r_cnt;
    assign o_stat.room2 = (r_cnt <= hpf_pkg::Q_CNT_W'(hpf_pkg::Q_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wp] <= i_d0;
        end
        if (i_push.push1) begin
            r_mem[w_wp1] <= i_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + w_npush[hpf_pkg::Q_PTR_W-1:0];
            if (i_pop) begin
                r_rp <= r_rp + hpf_pkg::Q_PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule
